@@ rtl/msrt_pkg.sv @@
// Package for the multi-slot repeat timer.
// Holds request and result types, codes and shared constants; depends on nothing.
`default_nettype none
package msrt_pkg;

    localparam int DEF_NUM_SLOTS = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_CREATE = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    localparam logic [1:0] EV_CREATED = 2'd0;
    localparam logic [1:0] EV_FULL    = 2'd1;
    localparam logic [1:0] EV_EXPIRED = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] period;
        logic [31:0] repeat_count;
        logic        repeat_forever;
        logic [31:0] start_delay;
        logic [7:0]  target_slot;
    } req_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [5:0] slot;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [31:0] reload;
        logic [31:0] count;
    } cnt_t;

    typedef struct packed {
        logic [31:0] repeats;
        logic        forever_flag;
        logic [31:0] delay;
    } ctl_t;

    typedef struct packed {
        logic cnt_en;
        logic ctl_en;
        cnt_t cnt;
        ctl_t ctl;
    } mem_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FLUSH
    } state_t;

endpackage
`default_nettype wire

@@ rtl/msrt_slot_mem.sv @@
// Slot storage: a counter memory and a control memory, each with a registered read.
// Uses msrt_pkg; entries never written read as zero through per-entry valid bits.
`default_nettype none
module msrt_slot_mem
    import msrt_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_addr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire mem_wr_t          wr,
    output cnt_t                  rd_cnt,
    output ctl_t                  rd_ctl
);

    cnt_t cnt_mem [NUM_SLOTS];
    ctl_t ctl_mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] cnt_valid_reg;
    logic [NUM_SLOTS-1:0] ctl_valid_reg;
    logic                 cnt_rvalid_reg;
    logic                 ctl_rvalid_reg;
    cnt_t                 cnt_q_reg;
    ctl_t                 ctl_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.cnt_en)
        begin
            cnt_mem[wr_addr] <= wr.cnt;
        end
        if (wr.ctl_en)
        begin
            ctl_mem[wr_addr] <= wr.ctl;
        end
        cnt_q_reg <= cnt_mem[rd_addr];
        ctl_q_reg <= ctl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg  <= '0;
            ctl_valid_reg  <= '0;
            cnt_rvalid_reg <= 1'b0;
            ctl_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr.cnt_en)
            begin
                cnt_valid_reg[wr_addr] <= 1'b1;
            end
            if (wr.ctl_en)
            begin
                ctl_valid_reg[wr_addr] <= 1'b1;
            end
            cnt_rvalid_reg <= cnt_valid_reg[rd_addr];
            ctl_rvalid_reg <= ctl_valid_reg[rd_addr];
        end
    end

    assign rd_cnt = cnt_rvalid_reg ? cnt_q_reg : '0;
    assign rd_ctl = ctl_rvalid_reg ? ctl_q_reg : '0;

endmodule
`default_nettype wire

@@ rtl/msrt_ctrl.sv @@
// Sequencer for create, stop and tick requests, with the running flags and result register.
// Uses msrt_pkg; drives the slot memories in msrt_slot_mem.
`default_nettype none
module msrt_ctrl
    import msrt_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire req_t             request,
    output logic                  busy,
    output logic                  strobe,
    output res_t                  result,
    output logic [IDX_W-1:0]      rd_addr,
    output logic [IDX_W-1:0]      wr_addr,
    output mem_wr_t               wr,
    input  wire cnt_t             rd_cnt,
    input  wire ctl_t             rd_ctl
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    state_t               state_reg, state_next;
    logic [NUM_SLOTS-1:0] running_reg, running_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_slot_reg, pend_slot_next;
    logic                 strobe_reg, strobe_next;
    res_t                 result_reg, result_next;

    logic             accept;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             tick_end;
    logic             expire;
    logic [31:0]      count_dec;
    logic [31:0]      repeats_dec;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!running_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign count_dec   = rd_cnt.count - 32'd1;
    assign repeats_dec = rd_ctl.repeats - 32'd1;

    always_comb
    begin
        tick_end = (idx_reg == LAST_IDX);
        expire   = 1'b0;
        if (rd_ctl.delay != 32'd0)
        begin
            tick_end = 1'b1;
        end
        else if (running_reg[idx_reg] && (count_dec == 32'd0))
        begin
            expire = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.mode == MODE_TICK))
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (tick_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        running_next    = running_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        rd_addr         = '0;
        wr_addr         = idx_reg;
        wr.cnt_en       = 1'b0;
        wr.ctl_en       = 1'b0;
        wr.cnt          = rd_cnt;
        wr.ctl          = rd_ctl;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.mode)
                        MODE_TICK:
                        begin
                            idx_next        = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                        end
                        MODE_CREATE:
                        begin
                            strobe_next = 1'b1;
                            result_next.last = 1'b1;
                            if (free_found)
                            begin
                                running_next[free_idx] = 1'b1;
                                wr_addr                = free_idx;
                                wr.cnt_en              = 1'b1;
                                wr.ctl_en              = 1'b1;
                                wr.cnt.reload          = request.period;
                                wr.cnt.count           = request.period;
                                wr.ctl.repeats         = request.repeat_count;
                                wr.ctl.forever_flag    = request.repeat_forever;
                                wr.ctl.delay           = request.start_delay;
                                result_next.event_kind = EV_CREATED;
                                result_next.slot       = 6'(free_idx);
                            end
                            else
                            begin
                                result_next.event_kind = EV_FULL;
                                result_next.slot       = '0;
                            end
                        end
                        MODE_STOP:
                        begin
                            if ({1'b0, request.target_slot} < 9'(NUM_SLOTS))
                            begin
                                running_next[request.target_slot[IDX_W-1:0]] = 1'b0;
                                wr_addr   = request.target_slot[IDX_W-1:0];
                                wr.cnt_en = 1'b1;
                                wr.cnt    = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                rd_addr  = idx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (rd_ctl.delay != 32'd0)
                begin
                    wr.ctl_en    = 1'b1;
                    wr.ctl.delay = rd_ctl.delay - 32'd1;
                end
                else if (running_reg[idx_reg])
                begin
                    wr.cnt_en    = 1'b1;
                    wr.cnt.count = count_dec;
                    if (expire)
                    begin
                        if (rd_ctl.forever_flag)
                        begin
                            wr.cnt.count = rd_cnt.reload;
                        end
                        else
                        begin
                            wr.ctl_en      = 1'b1;
                            wr.ctl.repeats = repeats_dec;
                            if (repeats_dec == 32'd0)
                            begin
                                running_next[idx_reg] = 1'b0;
                                wr.cnt                = '0;
                            end
                        end
                    end
                end
                if (expire && (n_reg < RES_CNT_W'(MAX_RESULTS)))
                begin
                    n_next          = n_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_slot_next  = idx_reg;
                    if (pend_valid_reg)
                    begin
                        strobe_next            = 1'b1;
                        result_next.event_kind = EV_EXPIRED;
                        result_next.slot       = 6'(pend_slot_reg);
                        result_next.last       = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                pend_valid_next = 1'b0;
                if (pend_valid_reg)
                begin
                    strobe_next            = 1'b1;
                    result_next.event_kind = EV_EXPIRED;
                    result_next.slot       = 6'(pend_slot_reg);
                    result_next.last       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            running_reg    <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        result_reg    <= result_next;
    end

    a_tick_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.mode == MODE_TICK)) |=> (state_reg == ST_TICK && idx_reg == '0))
        else $error("tick did not start at slot zero");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("expiry count exceeded the result limit");

    a_last_expiry_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.event_kind == EV_EXPIRED && result_reg.last)
            |-> $past(state_reg) == ST_FLUSH)
        else $error("final expiry result not issued by the flush step");

    a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("expiry left pending after a tick");

endmodule
`default_nettype wire

@@ rtl/multi_slot_repeat_timer_top.sv @@
// Top level of the multi-slot repeat timer.
// Uses msrt_pkg; instantiates msrt_ctrl and msrt_slot_mem.
//
//  Channel   Signals                   Handshake
//  request   start, busy, request      taken at a clock edge with start high and busy low
//  result    strobe, result            valid for one cycle while strobe is high
//
// Create and stop requests never raise busy; a create result follows in the cycle
// after the request. A tick visits the slots in order, at most NUM_SLOTS of them,
// with one read-modify-write of the slot memories per slot, then a flush step.
// Each expiry result is held back until the next one or the end of the tick, so
// that the final one carries last. Reset clears all slots at once through valid bits.
// The receiver cannot stall results.
`default_nettype none
module multi_slot_repeat_timer_top
    import msrt_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output logic      busy,
    output logic      strobe,
    output res_t      result
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    mem_wr_t          wr;
    cnt_t             rd_cnt;
    ctl_t             rd_ctl;

    msrt_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_cnt  (rd_cnt),
        .rd_ctl  (rd_ctl)
    );

    msrt_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_cnt  (rd_cnt),
        .rd_ctl  (rd_ctl)
    );

endmodule
`default_nettype wire
